FILE: rtl/brle_pkg.sv
// Shared types, codes and helpers for the bitmap RLE decoder.
package brle_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_DX      = 3'd3,
    PH_DY      = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6
  } phase_t;

  localparam logic [1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam int DIM_W  = 13;
  localparam int POS_W  = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one pixel-write command, position still in col/row form
  typedef struct packed {
    logic             is_end;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [7:0]       count;
    logic [7:0]       even_value;
    logic [7:0]       odd_value;
  } cmd_t;

  function automatic logic [POS_W-1:0] sat_add16(input logic [POS_W-1:0] a,
                                                 input logic [7:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {{(POS_W-7){1'b0}}, b};
    return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

endpackage

FILE: rtl/brle_front.sv
// Byte parser: tracks escape codes and position, issues pixel-write commands.
module brle_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          rle4_mode,
  input  logic          q_full,
  output logic          enq_valid,
  output brle_pkg::cmd_t enq_cmd
);
  import brle_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       held_first_r, held_first_nxt;
  logic [7:0]       held_dx_r, held_dx_nxt;
  logic [7:0]       literal_left_r, literal_left_nxt;
  logic             pad_pending_r, pad_pending_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  logic       beat;
  logic [8:0] byte_inc;
  logic [7:0] lit_n;
  logic [7:0] lit_left;
  logic [7:0] ev_sel;
  logic [7:0] od_sel;

  assign in_ready = !q_full;
  assign beat     = in_valid && in_ready;
  assign byte_inc = {1'b0, in_byte} + 9'd1;
  assign ev_sel   = rle4_mode ? {4'b0, in_byte[7:4]} : in_byte;
  assign od_sel   = rle4_mode ? (in_byte & 8'h0f) : in_byte;
  assign lit_n    = !rle4_mode ? 8'd1 : (literal_left_r >= 8'd2 ? 8'd2 : literal_left_r);
  assign lit_left = (literal_left_r > lit_n) ? literal_left_r - lit_n : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_FIRST;
      held_first_r   <= '0;
      held_dx_r      <= '0;
      literal_left_r <= '0;
      pad_pending_r  <= 1'b0;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      phase_r        <= phase_nxt;
      held_first_r   <= held_first_nxt;
      held_dx_r      <= held_dx_nxt;
      literal_left_r <= literal_left_nxt;
      pad_pending_r  <= pad_pending_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    held_first_nxt   = held_first_r;
    held_dx_nxt      = held_dx_r;
    literal_left_nxt = literal_left_r;
    pad_pending_nxt  = pad_pending_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    enq_valid        = 1'b0;
    enq_cmd          = '0;
    enq_cmd.row      = row_r;
    enq_cmd.col      = col_r;
    if (beat) begin
      unique case (phase_r)
        PH_FIRST: begin
          held_first_nxt = in_byte;
          phase_nxt      = (in_byte == ESC_EOL) ? PH_ESCAPE : PH_VALUE;
        end
        PH_VALUE: begin
          phase_nxt          = PH_FIRST;
          enq_valid          = 1'b1;
          enq_cmd.count      = held_first_r;
          enq_cmd.even_value = ev_sel;
          enq_cmd.odd_value  = od_sel;
          col_nxt            = sat_add16(col_r, held_first_r);
        end
        PH_ESCAPE: begin
          unique case (in_byte)
            ESC_EOL: begin
              col_nxt   = '0;
              row_nxt   = sat_add16(row_r, 8'd1);
              phase_nxt = PH_FIRST;
            end
            ESC_EOI: begin
              enq_valid      = 1'b1;
              enq_cmd        = '0;
              enq_cmd.is_end = 1'b1;
              col_nxt        = '0;
              row_nxt        = '0;
              phase_nxt      = PH_FIRST;
            end
            ESC_DELTA: begin
              phase_nxt = PH_DX;
            end
            default: begin
              literal_left_nxt = in_byte;
              pad_pending_nxt  = rle4_mode ? byte_inc[1] : in_byte[0];
              phase_nxt        = PH_LITERAL;
            end
          endcase
        end
        PH_DX: begin
          held_dx_nxt = in_byte;
          phase_nxt   = PH_DY;
        end
        PH_DY: begin
          col_nxt   = sat_add16(col_r, held_dx_r);
          row_nxt   = sat_add16(row_r, in_byte);
          phase_nxt = PH_FIRST;
        end
        PH_LITERAL: begin
          enq_valid          = 1'b1;
          enq_cmd.count      = lit_n;
          enq_cmd.even_value = ev_sel;
          enq_cmd.odd_value  = od_sel;
          col_nxt            = sat_add16(col_r, lit_n);
          literal_left_nxt   = lit_left;
          if (lit_left == 8'd0) begin
            phase_nxt = pad_pending_r ? PH_PAD : PH_FIRST;
          end
        end
        default: begin
          pad_pending_nxt = 1'b0;
          phase_nxt       = PH_FIRST;
        end
      endcase
    end
  end

endmodule

FILE: rtl/brle_fifo.sv
// Short command queue between the parser and the index pipeline.
module brle_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           enq,
  input  brle_pkg::cmd_t enq_data,
  output logic           full,
  input  logic           deq,
  output brle_pkg::cmd_t deq_data,
  output logic           empty
);
  import brle_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_enq;
  logic              do_deq;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_enq   = enq && !full;
  assign do_deq   = deq && !empty;
  assign deq_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_enq && !do_deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_enq && do_deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem_r[wr_ptr_r] <= enq_data;
    end
  end

endmodule

FILE: rtl/brle_back.sv
// Index pipeline: width*row+col, range check against width*height, output register.
module brle_back #(
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  brle_pkg::cmd_t             q_data,
  output logic                       q_pop,
  input  logic [brle_pkg::DIM_W-1:0] image_width,
  input  logic [brle_pkg::DIM_W-1:0] image_height,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_is_end,
  output logic [23:0]                out_start_index,
  output logic [7:0]                 out_pixel_count,
  output logic [7:0]                 out_even_value,
  output logic [7:0]                 out_odd_value,
  output logic                       out_out_of_range
);
  import brle_pkg::*;

  localparam int PROD_W = DIM_W + POS_W;
  localparam int IDX_W  = PROD_W + 1;
  localparam int AREA_W = 2 * DIM_W;

  logic [POS_W-1:0] w_ext, h_ext, max_ext;
  logic [DIM_W-1:0] w_cl, h_cl;

  logic              va_r;
  logic [PROD_W-1:0] a_prod_r;
  logic [AREA_W-1:0] a_area_r;
  logic [POS_W-1:0]  a_col_r;
  logic [7:0]        a_cnt_r, a_ev_r, a_od_r;
  logic              a_end_r;

  logic              vb_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic [AREA_W-1:0] b_area_r;
  logic [7:0]        b_cnt_r, b_ev_r, b_od_r;
  logic              b_end_r;

  logic              vc_r;
  logic [IDX_W:0]    b_last;

  logic adv_a, adv_b, adv_c;

  assign max_ext = POS_W'(MAX_DIM);
  assign w_ext   = {{(POS_W-DIM_W){1'b0}}, image_width};
  assign h_ext   = {{(POS_W-DIM_W){1'b0}}, image_height};
  assign w_cl    = (w_ext > max_ext) ? max_ext[DIM_W-1:0] : image_width;
  assign h_cl    = (h_ext > max_ext) ? max_ext[DIM_W-1:0] : image_height;

  assign adv_c = !vc_r || out_ready;
  assign adv_b = !vb_r || adv_c;
  assign adv_a = !va_r || adv_b;
  assign q_pop = adv_a && !q_empty;

  assign b_last = {1'b0, b_idx_r} + (IDX_W+1)'(b_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= !q_empty;
      if (adv_b) vb_r <= va_r;
      if (adv_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_prod_r <= w_cl * q_data.row;
      a_area_r <= w_cl * h_cl;
      a_col_r  <= q_data.col;
      a_cnt_r  <= q_data.count;
      a_ev_r   <= q_data.even_value;
      a_od_r   <= q_data.odd_value;
      a_end_r  <= q_data.is_end;
    end
    if (adv_b) begin
      b_idx_r  <= {1'b0, a_prod_r} + IDX_W'(a_col_r);
      b_area_r <= a_area_r;
      b_cnt_r  <= a_cnt_r;
      b_ev_r   <= a_ev_r;
      b_od_r   <= a_od_r;
      b_end_r  <= a_end_r;
    end
    if (adv_c) begin
      out_start_index  <= b_idx_r[23:0];
      out_out_of_range <= b_last > (IDX_W+1)'(b_area_r);
      out_pixel_count  <= b_cnt_r;
      out_even_value   <= b_ev_r;
      out_odd_value    <= b_od_r;
      out_is_end       <= b_end_r;
    end
  end

  assign out_valid = vc_r;

endmodule

FILE: rtl/bitmap_rle_decoder_core.sv
// Top level of the bitmap RLE8/RLE4 decoder: config registers, parser, queue, index pipeline.
//
// Takes one compressed byte per beat and returns pixel-write commands (start index
// width*row+col, count, even/odd values, range flag) or an end-of-image beat. A byte is
// taken every cycle while the four-entry command queue has room; each command then
// passes three registered stages (multiply, add, range compare into the output
// register). While out_ready is held high the sustained rate is one byte per cycle.
// The user must write configuration through cfg_we, cfg_index and cfg_data only while
// the decoder is idle; the block itself does not enforce this.
module bitmap_rle_decoder_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_end,
  output logic [23:0] out_start_index,
  output logic [7:0]  out_pixel_count,
  output logic [7:0]  out_even_value,
  output logic [7:0]  out_odd_value,
  output logic        out_out_of_range,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import brle_pkg::*;

  logic             rle4_mode_r;
  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;

  cmd_t enq_cmd, deq_cmd;
  logic enq_valid, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle4_mode_r    <= 1'b0;
      image_width_r  <= DIM_W'(1);
      image_height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE:   rle4_mode_r    <= cfg_data[0];
        CFG_IDX_WIDTH:  image_width_r  <= cfg_data;
        CFG_IDX_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  brle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_stream_byte),
    .rle4_mode (rle4_mode_r),
    .q_full    (q_full),
    .enq_valid (enq_valid),
    .enq_cmd   (enq_cmd)
  );

  brle_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .enq      (enq_valid),
    .enq_data (enq_cmd),
    .full     (q_full),
    .deq      (q_pop),
    .deq_data (deq_cmd),
    .empty    (q_empty)
  );

  brle_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (deq_cmd),
    .q_pop            (q_pop),
    .image_width      (image_width_r),
    .image_height     (image_height_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_end       (out_is_end),
    .out_start_index  (out_start_index),
    .out_pixel_count  (out_pixel_count),
    .out_even_value   (out_even_value),
    .out_odd_value    (out_odd_value),
    .out_out_of_range (out_out_of_range)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the bitmap RLE8/RLE4 decoder core.
module tb;
  import brle_pkg::*;

  localparam int DIM_CAP = 4096;
  localparam logic [7:0] RUN_ESCAPE = 8'd0;
  localparam int LONG_STALL = 300;

  typedef struct {
    logic        is_end;
    logic [23:0] start_index;
    logic [7:0]  pixel_count;
    logic [7:0]  even_value;
    logic [7:0]  odd_value;
    logic        out_of_range;
  } pixel_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_IDX_MODE;
  logic [12:0] cfg_data = 13'd0;
  logic        in_ready;
  logic        out_valid;
  logic        out_is_end;
  logic [23:0] out_start_index;
  logic [7:0]  out_pixel_count;
  logic [7:0]  out_even_value;
  logic [7:0]  out_odd_value;
  logic        out_out_of_range;

  always #5 clk = ~clk;

  bitmap_rle_decoder_core #(.MAX_DIM(DIM_CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_stream_byte(in_stream_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_is_end(out_is_end),
    .out_start_index(out_start_index),
    .out_pixel_count(out_pixel_count),
    .out_even_value(out_even_value),
    .out_odd_value(out_odd_value),
    .out_out_of_range(out_out_of_range),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // decoder mirror
  logic        m_rle4 = 1'b0;
  logic [12:0] m_width = 13'd1;
  logic [12:0] m_height = 13'd1;
  phase_t      dec_phase = PH_FIRST;
  logic [7:0]  run_len = 8'd0;
  logic [7:0]  dx_hold = 8'd0;
  logic [7:0]  lit_left = 8'd0;
  logic        pad_due = 1'b0;
  logic [15:0] cur_col = 16'd0;
  logic [15:0] cur_row = 16'd0;

  pixel_cmd_t  pixel_cmds_due[$];
  logic [7:0]  stream_q[$];
  int          gen_count = 0;
  int          mismatch_count = 0;

  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  int          mon_cycle = 0;
  bit          long_stall_req = 1'b0;
  bit          ready_nxt;

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [7:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 65535) ? 16'hFFFF : 16'(s);
  endfunction

  task automatic predict_pixels(input logic [7:0] count, input logic [7:0] ev,
                                input logic [7:0] od);
    longint unsigned w, h, idx;
    pixel_cmd_t c;
    w = (m_width > DIM_CAP) ? DIM_CAP : m_width;
    h = (m_height > DIM_CAP) ? DIM_CAP : m_height;
    idx = w * cur_row + cur_col;
    c.is_end = 1'b0;
    c.start_index = 24'(idx);
    c.pixel_count = count;
    c.even_value = ev;
    c.odd_value = od;
    c.out_of_range = (idx + count > w * h);
    pixel_cmds_due.push_back(c);
    cur_col = sat16(cur_col, count);
  endtask

  task automatic decode_stream_byte(input logic [7:0] b);
    logic [7:0] hi, lo, n;
    logic [8:0] half;
    pixel_cmd_t c;
    hi = {4'h0, b[7:4]};
    lo = {4'h0, b[3:0]};
    case (dec_phase)
      PH_FIRST: begin
        run_len = b;
        dec_phase = (b == RUN_ESCAPE) ? PH_ESCAPE : PH_VALUE;
      end
      PH_VALUE: begin
        dec_phase = PH_FIRST;
        if (m_rle4) predict_pixels(run_len, hi, lo);
        else predict_pixels(run_len, b, b);
      end
      PH_ESCAPE: begin
        dec_phase = PH_FIRST;
        if (b == ESC_EOL) begin
          cur_col = 16'd0;
          cur_row = sat16(cur_row, 8'd1);
        end else if (b == ESC_EOI) begin
          c.is_end = 1'b1;
          c.start_index = 24'd0;
          c.pixel_count = 8'd0;
          c.even_value = 8'd0;
          c.odd_value = 8'd0;
          c.out_of_range = 1'b0;
          pixel_cmds_due.push_back(c);
          cur_col = 16'd0;
          cur_row = 16'd0;
        end else if (b == ESC_DELTA) begin
          dec_phase = PH_DX;
        end else begin
          lit_left = b;
          half = ({1'b0, b} + 9'd1) >> 1;
          pad_due = m_rle4 ? half[0] : b[0];
          dec_phase = PH_LITERAL;
        end
      end
      PH_DX: begin
        dx_hold = b;
        dec_phase = PH_DY;
      end
      PH_DY: begin
        cur_col = sat16(cur_col, dx_hold);
        cur_row = sat16(cur_row, b);
        dec_phase = PH_FIRST;
      end
      PH_LITERAL: begin
        if (m_rle4) begin
          n = (lit_left >= 8'd2) ? 8'd2 : lit_left;
          predict_pixels(n, hi, lo);
        end else begin
          n = 8'd1;
          predict_pixels(n, b, b);
        end
        lit_left = (lit_left > n) ? lit_left - n : 8'd0;
        if (lit_left == 8'd0) dec_phase = pad_due ? PH_PAD : PH_FIRST;
      end
      default: begin
        pad_due = 1'b0;
        dec_phase = PH_FIRST;
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic check_beat();
    pixel_cmd_t e;
    if (pixel_cmds_due.size() == 0) begin
      report_mismatch($sformatf("beat with nothing due, start_index %0d", out_start_index));
      return;
    end
    e = pixel_cmds_due.pop_front();
    if (out_is_end !== e.is_end)
      report_mismatch($sformatf("is_end %b, want %b", out_is_end, e.is_end));
    if (out_start_index !== e.start_index)
      report_mismatch($sformatf("start_index %0d, want %0d", out_start_index, e.start_index));
    if (out_pixel_count !== e.pixel_count)
      report_mismatch($sformatf("pixel_count %0d, want %0d", out_pixel_count, e.pixel_count));
    if (out_even_value !== e.even_value)
      report_mismatch($sformatf("even_value %h, want %h", out_even_value, e.even_value));
    if (out_odd_value !== e.odd_value)
      report_mismatch($sformatf("odd_value %h, want %h", out_odd_value, e.odd_value));
    if (out_out_of_range !== e.out_of_range)
      report_mismatch($sformatf("out_of_range %b, want %b", out_out_of_range, e.out_of_range));
  endtask

  // input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_stream_byte(in_stream_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          in_valid <= 1'b1;
          in_stream_byte <= stream_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output beats
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_beat();
      mon_cycle++;
      if (mon_cycle % 64 == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      if (long_stall_req) begin
        stall_left = LONG_STALL;
        long_stall_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = ($urandom_range(0, 99) >= stall_pct);
      end
      out_ready <= ready_nxt;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_q.push_back(b);
    gen_count++;
  endtask

  task automatic push_run(input logic [7:0] n, input logic [7:0] v);
    push_byte(n);
    push_byte(v);
  endtask

  task automatic push_escape(input logic [7:0] code);
    push_byte(RUN_ESCAPE);
    push_byte(code);
  endtask

  task automatic push_delta(input logic [7:0] dx, input logic [7:0] dy);
    push_escape(ESC_DELTA);
    push_byte(dx);
    push_byte(dy);
  endtask

  // absolute run of n pixels; keep < body cuts it short
  task automatic push_literal(input int n, input int keep);
    int body;
    body = m_rle4 ? (n + 1) / 2 : n;
    push_escape(8'(n));
    for (int i = 0; i < body && i < keep; i++) push_byte(8'($urandom));
    if (keep >= body && body % 2 == 1) push_byte(8'($urandom));
  endtask

  // bring the parser back to the start of a pair
  task automatic align_stream();
    int fill;
    case (dec_phase)
      PH_ESCAPE: push_byte(ESC_EOL);
      PH_VALUE, PH_DY, PH_PAD: push_byte(8'($urandom));
      PH_DX: begin
        push_byte(8'($urandom));
        push_byte(8'($urandom));
      end
      PH_LITERAL: begin
        fill = (m_rle4 ? (lit_left + 1) / 2 : lit_left) + pad_due;
        repeat (fill) push_byte(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_valid || pixel_cmds_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [12:0] w, input logic [12:0] h);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_data <= {12'd0, mode};
    @(posedge clk);
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_rle4 = mode;
    m_width = w;
    m_height = h;
  endtask

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return 13'd4097;
      default: return 13'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic random_phase(input int quota);
    int start, sel, n, body;
    start = gen_count;
    while (gen_count - start < quota) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 255);
        push_run(8'(n), 8'($urandom));
      end else if (sel < 65) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
        push_literal(n, 256);
      end else if (sel < 75) begin
        push_escape(ESC_EOL);
      end else if (sel < 85) begin
        if ($urandom_range(0, 1) == 0) push_delta(8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)));
        else push_delta(8'($urandom), 8'($urandom));
      end else if (sel < 91) begin
        push_escape(ESC_EOI);
      end else if (sel < 96) begin
        push_byte(8'($urandom));
      end else begin
        n = $urandom_range(3, 12);
        body = m_rle4 ? (n + 1) / 2 : n;
        push_literal(n, $urandom_range(0, body - 1));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(3, 20);
      body = m_rle4 ? (n + 1) / 2 : n;
      push_literal(n, $urandom_range(0, body - 1));
    end
  endtask

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [12:0] w, h;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // RLE8 basics on a 4x2 image
    set_config(1'b0, 13'd4, 13'd2);
    push_run(8'd3, 8'hFF);
    push_run(8'd255, 8'h00);
    push_escape(ESC_EOL);
    push_delta(8'd1, 8'd0);
    push_literal(3, 256);
    push_escape(ESC_EOI);
    wait_idle();

    // RLE4 basics on a 5x3 image
    set_config(1'b1, 13'd5, 13'd3);
    push_run(8'd5, 8'hA5);
    push_literal(5, 256);
    push_literal(3, 256);
    push_escape(ESC_EOI);
    wait_idle();

    for (int p = 0; p < 11; p++) begin
      w = pick_dim();
      h = pick_dim();
      if (p == 0) w = 13'd0;
      if (p == 1) begin
        w = 13'd8191;
        h = 13'd8191;
      end
      if (p == 3) h = 13'd0;
      set_config(1'($urandom_range(0, 1)), w, h);
      align_stream();
      if (p == 2) long_stall_req = 1'b1;
      random_phase(40);
      wait_idle();
    end

    // runaway position: col saturates
    set_config(1'($urandom_range(0, 1)), 13'd4096, 13'd4096);
    align_stream();
    push_delta(8'd255, 8'd255);
    repeat (258) push_run(8'd255, 8'($urandom));
    push_literal(5, 256);
    push_escape(ESC_EOI);
    push_run(8'd2, 8'h3C);
    wait_idle();

    repeat (20) @(posedge clk);
    if (pixel_cmds_due.size() != 0)
      report_mismatch($sformatf("%0d commands never arrived", pixel_cmds_due.size()));
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: bitmap_rle_decoder_core.f
rtl/brle_pkg.sv
rtl/brle_front.sv
rtl/brle_fifo.sv
rtl/brle_back.sv
rtl/bitmap_rle_decoder_core.sv
verif/tb.sv
